>>> rtl/core/mono_framebuffer_draw_engine_top_defines.svh
// Assertion macros shared by the draw engine modules.
// Every module that uses them has ports named clock and reset.
`ifndef MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_DEFINES_SVH
`define MONO_FRAMEBUFFER_DRAW_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MFDE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define MFDE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/mfde_pkg.sv
`timescale 1ns / 1ps

package mfde_pkg;

   // Display geometry.
   localparam int DISPLAY_COLUMNS = 128;
   localparam int DISPLAY_PAGES   = 8;
   localparam int STORE_BYTES     = DISPLAY_COLUMNS * DISPLAY_PAGES;
   localparam int STORE_ADDR_W    = $clog2(STORE_BYTES);

   localparam logic [8:0] COLS_LIMIT  = 9'(DISPLAY_COLUMNS);
   localparam logic [5:0] PAGES_LIMIT = 6'(DISPLAY_PAGES);

   typedef logic [STORE_ADDR_W-1:0] store_addr_type;

   localparam store_addr_type STORE_LAST = STORE_ADDR_W'(STORE_BYTES - 1);

   // Request types.
   localparam logic [2:0] REQ_CLEAR  = 3'd0;
   localparam logic [2:0] REQ_POINT  = 3'd1;
   localparam logic [2:0] REQ_LINE   = 3'd2;
   localparam logic [2:0] REQ_CIRCLE = 3'd3;
   localparam logic [2:0] REQ_READ   = 3'd4;

   // Pixel unit operations.
   localparam logic [1:0] PX_PLOT  = 2'd0;
   localparam logic [1:0] PX_READ  = 2'd1;
   localparam logic [1:0] PX_CLEAR = 2'd2;

   // Width of the squarer operand.
   localparam int SQ_IN_W = 9;

   // Command from the sequencer to the pixel unit.
   typedef struct packed {
      logic       valid;
      logic [1:0] op;
      logic [7:0] x;
      logic [7:0] y;
      logic       set;
      logic [6:0] rcol;
      logic [2:0] rpage;
   } pix_cmd_type;

   // Status from the pixel unit back to the sequencer.
   typedef struct packed {
      logic       idle;
      logic       done;
      logic       clipped;
      logic [7:0] data;
   } pix_stat_type;

   // Byte address of a column and page.
   function automatic store_addr_type store_index(input logic [7:0] col,
                                                  input logic [4:0] page);
      return STORE_ADDR_W'(int'(col) * DISPLAY_PAGES + int'(page));
   endfunction

   // Bit mask of a row inside its page.
   function automatic logic [7:0] bit_mask(input logic [2:0] m);
      return 8'(1) << m;
   endfunction

endpackage

>>> rtl/core/mfde_channel_if.sv
`timescale 1ns / 1ps

// Drawing request channel.
interface mfde_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] pos_x_a;
   logic [7:0] pos_y_a;
   logic [7:0] pos_x_b;
   logic [7:0] pos_y_b;
   logic [7:0] radius;
   logic       set_mode;
   logic [6:0] read_column;
   logic [2:0] read_page;

   modport source (output valid, output req_type, output pos_x_a, output pos_y_a,
                   output pos_x_b, output pos_y_b, output radius, output set_mode,
                   output read_column, output read_page, input ready);
   modport sink (input valid, input req_type, input pos_x_a, input pos_y_a,
                 input pos_x_b, input pos_y_b, input radius, input set_mode,
                 input read_column, input read_page, output ready);
endinterface

// Result channel.
interface mfde_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       clipped_any;

   modport source (output valid, output read_data, output clipped_any, input ready);
   modport sink (input valid, input read_data, input clipped_any, output ready);
endinterface

>>> rtl/core/mfde_square_unit.sv
`timescale 1ns / 1ps

// Shared squarer with a registered product; the product is valid in the cycle
// after the operand is presented.
module mfde_square_unit import mfde_pkg::*; (
   input  logic                   clock,
   input  logic [SQ_IN_W-1:0]     operand,
   output logic [2*SQ_IN_W-1:0]   square
);

   logic [2*SQ_IN_W-1:0] square_ff;
   logic [2*SQ_IN_W-1:0] square_in;

   assign square_in = operand * operand;

   always_ff @(posedge clock) begin
      square_ff <= square_in;
   end

   assign square = square_ff;

endmodule

>>> rtl/core/mfde_pixel_unit.sv
`timescale 1ns / 1ps

// Framebuffer store with read-modify-write of single pixels, byte reads and
// a clearing sweep. A sweep runs after reset and on every clear command.
module mfde_pixel_unit import mfde_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  pix_cmd_type  pix_cmd,
   output pix_stat_type pix_stat
);

`include "mono_framebuffer_draw_engine_top_defines.svh"

   localparam logic [1:0] P_IDLE   = 2'd0;
   localparam logic [1:0] P_MODIFY = 2'd1;
   localparam logic [1:0] P_RDATA  = 2'd2;
   localparam logic [1:0] P_CLEAR  = 2'd3;

   logic [7:0] store_mem [STORE_BYTES];

   logic [1:0]     state_ff, state_in;
   store_addr_type clr_cnt_ff, clr_cnt_in;
   store_addr_type addr_ff, addr_in;
   logic [7:0]     mask_ff, mask_in;
   logic           set_ff, set_in;
   logic           done_ff, done_in;
   logic           clip_ff, clip_in;
   logic [7:0]     data_ff, data_in;
   logic [7:0]     rd_data_ff;

   logic [4:0]     page;
   logic           plot_in_range;
   logic           read_in_range;
   store_addr_type plot_addr;
   store_addr_type read_addr;
   store_addr_type rd_addr;
   logic           wr_en;
   store_addr_type wr_addr;
   logic [7:0]     wr_data;

   // Address decode and clipping of the incoming command.
   assign page          = pix_cmd.y[7:3];
   assign plot_in_range = ({1'b0, pix_cmd.x} < COLS_LIMIT) && ({1'b0, page} < PAGES_LIMIT);
   assign read_in_range = ({2'b0, pix_cmd.rcol} < COLS_LIMIT)
                          && ({3'b0, pix_cmd.rpage} < PAGES_LIMIT);
   assign plot_addr     = store_index(pix_cmd.x, page);
   assign read_addr     = store_index({1'b0, pix_cmd.rcol}, {2'b0, pix_cmd.rpage});
   assign rd_addr       = (pix_cmd.op == PX_READ) ? read_addr : plot_addr;

   // Control sequencing.
   always_comb begin
      state_in   = state_ff;
      clr_cnt_in = clr_cnt_ff;
      addr_in    = addr_ff;
      mask_in    = mask_ff;
      set_in     = set_ff;
      done_in    = 1'b0;
      clip_in    = 1'b0;
      data_in    = '0;
      wr_en      = 1'b0;
      wr_addr    = addr_ff;
      wr_data    = set_ff ? (rd_data_ff | mask_ff) : (rd_data_ff & ~mask_ff);
      unique case (state_ff)
         P_IDLE: begin
            if (pix_cmd.valid) begin
               unique case (pix_cmd.op)
                  PX_PLOT: begin
                     if (plot_in_range) begin
                        addr_in  = plot_addr;
                        mask_in  = bit_mask(pix_cmd.y[2:0]);
                        set_in   = pix_cmd.set;
                        state_in = P_MODIFY;
                     end else begin
                        done_in = 1'b1;
                        clip_in = 1'b1;
                     end
                  end
                  PX_READ: begin
                     if (read_in_range) begin
                        state_in = P_RDATA;
                     end else begin
                        done_in = 1'b1;
                     end
                  end
                  PX_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = P_CLEAR;
                  end
                  default: begin
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         P_MODIFY: begin
            wr_en    = 1'b1;
            done_in  = 1'b1;
            state_in = P_IDLE;
         end
         P_RDATA: begin
            done_in  = 1'b1;
            data_in  = rd_data_ff;
            state_in = P_IDLE;
         end
         P_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_ff;
            wr_data = '0;
            if (clr_cnt_ff == STORE_LAST) begin
               done_in  = 1'b1;
               state_in = P_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = P_IDLE;
         end
      endcase
   end

   // Control registers; reset starts the clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= P_CLEAR;
         clr_cnt_ff <= '0;
         done_ff    <= 1'b0;
         clip_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         done_ff    <= done_in;
         clip_ff    <= clip_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      mask_ff <= mask_in;
      set_ff  <= set_in;
      data_ff <= data_in;
   end

   // Frame store: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign pix_stat.idle    = (state_ff == P_IDLE);
   assign pix_stat.done    = done_ff;
   assign pix_stat.clipped = clip_ff;
   assign pix_stat.data    = data_ff;

   `MFDE_ASSERT_IMPL(a_cmd_only_when_idle, pix_cmd.valid, state_ff == P_IDLE, "pixel command while busy")
   `MFDE_ASSERT_NEXT(a_done_single_pulse, done_ff, !done_ff, "pixel done held for two cycles")
   `MFDE_ASSERT_IMPL(a_clip_from_idle, done_ff && clip_ff, $past(state_ff) == P_IDLE, "clip reported after a store access")

endmodule

>>> rtl/core/mono_framebuffer_draw_engine_top.sv
`timescale 1ns / 1ps

// Drawing engine for a 128 x 64 page-organized monochrome framebuffer: each request clears
// the store, sets or clears one point, draws a line, draws a circle or reads one byte back
// (an unknown type does nothing), and returns exactly one result with the byte read (zero
// otherwise) and a flag for any point that fell off the display. Requests are taken one at
// a time and every pixel is a read-modify-write of its store byte; a pixel that falls off
// the display is not written. A circle's octant step plots eight pixels and makes two
// squarings on the shared 9 x 9 squarer, and a clear sweeps all 1024 bytes. After reset the
// same clearing sweep runs before the first request is taken. A finished result waits
// in an output register while the next request is accepted; only a result that finds the
// previous one still unaccepted holds the engine until the receiver takes it.
module mono_framebuffer_draw_engine_top import mfde_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mfde_req_if.sink   req_chan,
   mfde_rsp_if.source rsp_chan
);

`include "mono_framebuffer_draw_engine_top_defines.svh"

   localparam logic [3:0] S_IDLE        = 4'd0;
   localparam logic [3:0] S_PIX_ISSUE   = 4'd1;
   localparam logic [3:0] S_PIX_WAIT    = 4'd2;
   localparam logic [3:0] S_RESULT      = 4'd3;
   localparam logic [3:0] S_L_INIT      = 4'd4;
   localparam logic [3:0] S_L_PLOT      = 4'd5;
   localparam logic [3:0] S_L_WAIT      = 4'd6;
   localparam logic [3:0] S_C_INIT      = 4'd7;
   localparam logic [3:0] S_C_RR        = 4'd8;
   localparam logic [3:0] S_C_CHK_ISSUE = 4'd9;
   localparam logic [3:0] S_C_CHKB      = 4'd10;
   localparam logic [3:0] S_C_PLOT      = 4'd11;
   localparam logic [3:0] S_C_WAIT      = 4'd12;
   localparam logic [3:0] S_C_MULA      = 4'd13;
   localparam logic [3:0] S_C_STEP      = 4'd14;

   logic [3:0] state_ff, state_in;
   logic [2:0] type_ff, type_in;
   logic [7:0] x_a_ff, x_a_in;
   logic [7:0] y_a_ff, y_a_in;
   logic       set_ff, set_in;
   logic [7:0] radius_ff, radius_in;
   logic [6:0] rcol_ff, rcol_in;
   logic [2:0] rpage_ff, rpage_in;
   logic [7:0] dx_ff, dx_in;
   logic [7:0] dy_ff, dy_in;
   logic       neg_x_ff, neg_x_in;
   logic       neg_y_ff, neg_y_in;
   logic [7:0] dist_ff, dist_in;
   logic [7:0] walk_x_ff, walk_x_in;
   logic [7:0] walk_y_ff, walk_y_in;
   logic [9:0] err_x_ff, err_x_in;
   logic [9:0] err_y_ff, err_y_in;
   logic [8:0] step_left_ff, step_left_in;
   logic [7:0] a_ff, a_in;
   logic [8:0] b_ff, b_in;
   logic [2:0] oct_ff, oct_in;
   logic [15:0] rr_ff, rr_in;
   logic [15:0] sq_b_ff, sq_b_in;
   logic       clip_ff, clip_in;
   logic [7:0] data_ff, data_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic       rsp_clip_ff, rsp_clip_in;

   logic                 req_fire;
   logic                 rsp_free;
   logic [SQ_IN_W-1:0]   sq_operand;
   logic [2*SQ_IN_W-1:0] sq_result;
   logic [15:0]          sq_low;
   logic [9:0]           ex_sum;
   logic [9:0]           ey_sum;
   logic [7:0]           circ_x;
   logic [7:0]           circ_y;
   pix_cmd_type          pix_cmd;
   pix_stat_type         pix_stat;

   mfde_square_unit u_square (
      .clock   (clock),
      .operand (sq_operand),
      .square  (sq_result)
   );

   mfde_pixel_unit u_pixel (
      .clock    (clock),
      .reset    (reset),
      .pix_cmd  (pix_cmd),
      .pix_stat (pix_stat)
   );

   assign req_chan.ready = (state_ff == S_IDLE) && pix_stat.idle;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign sq_low         = sq_result[15:0];

   // Line error accumulation.
   assign ex_sum = err_x_ff + {2'b0, dx_ff};
   assign ey_sum = err_y_ff + {2'b0, dy_ff};

   // The eight mirrored points of one circle step.
   always_comb begin
      unique case (oct_ff)
         3'd0: begin circ_x = x_a_ff + a_ff;      circ_y = y_a_ff - b_ff[7:0]; end
         3'd1: begin circ_x = x_a_ff - a_ff;      circ_y = y_a_ff - b_ff[7:0]; end
         3'd2: begin circ_x = x_a_ff - a_ff;      circ_y = y_a_ff + b_ff[7:0]; end
         3'd3: begin circ_x = x_a_ff + a_ff;      circ_y = y_a_ff + b_ff[7:0]; end
         3'd4: begin circ_x = x_a_ff + b_ff[7:0]; circ_y = y_a_ff + a_ff;      end
         3'd5: begin circ_x = x_a_ff + b_ff[7:0]; circ_y = y_a_ff - a_ff;      end
         3'd6: begin circ_x = x_a_ff - b_ff[7:0]; circ_y = y_a_ff - a_ff;      end
         3'd7: begin circ_x = x_a_ff - b_ff[7:0]; circ_y = y_a_ff + a_ff;      end
         default: begin circ_x = x_a_ff; circ_y = y_a_ff; end
      endcase
   end

   // Pixel commands and squarer operands issued by the sequencer.
   always_comb begin
      pix_cmd       = '0;
      pix_cmd.set   = set_ff;
      pix_cmd.rcol  = rcol_ff;
      pix_cmd.rpage = rpage_ff;
      pix_cmd.op    = PX_PLOT;
      pix_cmd.x     = x_a_ff;
      pix_cmd.y     = y_a_ff;
      sq_operand    = '0;
      unique case (state_ff)
         S_PIX_ISSUE: begin
            pix_cmd.valid = 1'b1;
            if (type_ff == REQ_CLEAR) begin
               pix_cmd.op = PX_CLEAR;
            end else if (type_ff == REQ_READ) begin
               pix_cmd.op = PX_READ;
            end
         end
         S_L_PLOT: begin
            pix_cmd.valid = 1'b1;
            pix_cmd.x     = walk_x_ff;
            pix_cmd.y     = walk_y_ff;
         end
         S_C_PLOT: begin
            pix_cmd.valid = 1'b1;
            pix_cmd.x     = circ_x;
            pix_cmd.y     = circ_y;
         end
         S_C_INIT:      sq_operand = {1'b0, radius_ff};
         S_C_CHK_ISSUE: sq_operand = b_ff;
         S_C_MULA:      sq_operand = {1'b0, a_ff} + 1'b1;
         default: begin
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      type_in      = type_ff;
      x_a_in       = x_a_ff;
      y_a_in       = y_a_ff;
      set_in       = set_ff;
      radius_in    = radius_ff;
      rcol_in      = rcol_ff;
      rpage_in     = rpage_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      dist_in      = dist_ff;
      walk_x_in    = walk_x_ff;
      walk_y_in    = walk_y_ff;
      err_x_in     = err_x_ff;
      err_y_in     = err_y_ff;
      step_left_in = step_left_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      oct_in       = oct_ff;
      rr_in        = rr_ff;
      sq_b_in      = sq_b_ff;
      clip_in      = clip_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_clip_in  = rsp_clip_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               type_in   = req_chan.req_type;
               x_a_in    = req_chan.pos_x_a;
               y_a_in    = req_chan.pos_y_a;
               set_in    = req_chan.set_mode;
               radius_in = req_chan.radius;
               rcol_in   = req_chan.read_column;
               rpage_in  = req_chan.read_page;
               neg_x_in  = req_chan.pos_x_b < req_chan.pos_x_a;
               neg_y_in  = req_chan.pos_y_b < req_chan.pos_y_a;
               dx_in     = neg_x_in ? (req_chan.pos_x_a - req_chan.pos_x_b)
                                    : (req_chan.pos_x_b - req_chan.pos_x_a);
               dy_in     = neg_y_in ? (req_chan.pos_y_a - req_chan.pos_y_b)
                                    : (req_chan.pos_y_b - req_chan.pos_y_a);
               walk_x_in = req_chan.pos_x_a;
               walk_y_in = req_chan.pos_y_a;
               err_x_in  = '0;
               err_y_in  = '0;
               a_in      = '0;
               b_in      = {1'b0, req_chan.radius};
               clip_in   = 1'b0;
               data_in   = '0;
               unique case (req_chan.req_type)
                  REQ_CLEAR, REQ_POINT, REQ_READ: state_in = S_PIX_ISSUE;
                  REQ_LINE:                       state_in = S_L_INIT;
                  REQ_CIRCLE:                     state_in = S_C_INIT;
                  default:                        state_in = S_RESULT;
               endcase
            end
         end
         S_PIX_ISSUE: begin
            state_in = S_PIX_WAIT;
         end
         S_PIX_WAIT: begin
            if (pix_stat.done) begin
               clip_in  = pix_stat.clipped;
               data_in  = pix_stat.data;
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = data_ff;
               rsp_clip_in  = clip_ff;
               state_in     = S_IDLE;
            end
         end
         S_L_INIT: begin
            dist_in      = (dx_ff > dy_ff) ? dx_ff : dy_ff;
            step_left_in = {1'b0, dist_in} + 1'b1;
            state_in     = S_L_PLOT;
         end
         S_L_PLOT: begin
            state_in = S_L_WAIT;
         end
         S_L_WAIT: begin
            if (pix_stat.done) begin
               clip_in = clip_ff | pix_stat.clipped;
               // Each axis steps when its error passes the longer span.
               if (ex_sum > {2'b0, dist_ff}) begin
                  err_x_in  = ex_sum - {2'b0, dist_ff};
                  walk_x_in = neg_x_ff ? (walk_x_ff - 1'b1) : (walk_x_ff + 1'b1);
               end else begin
                  err_x_in = ex_sum;
               end
               if (ey_sum > {2'b0, dist_ff}) begin
                  err_y_in  = ey_sum - {2'b0, dist_ff};
                  walk_y_in = neg_y_ff ? (walk_y_ff - 1'b1) : (walk_y_ff + 1'b1);
               end else begin
                  err_y_in = ey_sum;
               end
               step_left_in = step_left_ff - 1'b1;
               state_in     = (step_left_ff == 9'd1) ? S_RESULT : S_L_PLOT;
            end
         end
         S_C_INIT: begin
            state_in = S_C_RR;
         end
         S_C_RR: begin
            rr_in    = sq_low;
            state_in = S_C_CHK_ISSUE;
         end
         S_C_CHK_ISSUE: begin
            // A negative offset ends the walk.
            state_in = b_ff[8] ? S_RESULT : S_C_CHKB;
         end
         S_C_CHKB: begin
            sq_b_in = sq_low;
            if ({sq_low, 1'b0} >= {1'b0, rr_ff}) begin
               oct_in   = '0;
               state_in = S_C_PLOT;
            end else begin
               state_in = S_RESULT;
            end
         end
         S_C_PLOT: begin
            state_in = S_C_WAIT;
         end
         S_C_WAIT: begin
            if (pix_stat.done) begin
               clip_in = clip_ff | pix_stat.clipped;
               if (oct_ff == 3'd7) begin
                  state_in = S_C_MULA;
               end else begin
                  oct_in   = oct_ff + 1'b1;
                  state_in = S_C_PLOT;
               end
            end
         end
         S_C_MULA: begin
            state_in = S_C_STEP;
         end
         S_C_STEP: begin
            // Outside the radius: pull b in and keep a; otherwise advance a.
            if (({1'b0, sq_low} + {1'b0, sq_b_ff}) > {1'b0, rr_ff}) begin
               b_in = b_ff - 1'b1;
            end else begin
               a_in = a_ff + 1'b1;
            end
            state_in = S_C_CHK_ISSUE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         step_left_ff <= '0;
         b_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_left_ff <= step_left_in;
         b_ff         <= b_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      type_ff     <= type_in;
      x_a_ff      <= x_a_in;
      y_a_ff      <= y_a_in;
      set_ff      <= set_in;
      radius_ff   <= radius_in;
      rcol_ff     <= rcol_in;
      rpage_ff    <= rpage_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      neg_x_ff    <= neg_x_in;
      neg_y_ff    <= neg_y_in;
      dist_ff     <= dist_in;
      walk_x_ff   <= walk_x_in;
      walk_y_ff   <= walk_y_in;
      err_x_ff    <= err_x_in;
      err_y_ff    <= err_y_in;
      a_ff        <= a_in;
      oct_ff      <= oct_in;
      rr_ff       <= rr_in;
      sq_b_ff     <= sq_b_in;
      clip_ff     <= clip_in;
      data_ff     <= data_in;
      rsp_data_ff <= rsp_data_in;
      rsp_clip_ff <= rsp_clip_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.read_data   = rsp_data_ff;
   assign rsp_chan.clipped_any = rsp_clip_ff;

   `MFDE_ASSERT_IMPL(a_b_floor, b_ff[8], &b_ff, "circle offset went below minus one")
   `MFDE_ASSERT_IMPL(a_line_steps_left, state_ff == S_L_PLOT, step_left_ff != 9'd0, "no steps")
   `MFDE_ASSERT_IMPL(a_read_not_clipped, rsp_valid_ff && (rsp_data_ff != '0), !rsp_clip_ff, "clip")

endmodule

>>> test/mono_framebuffer_draw_engine_top_test.sv
`timescale 1ns / 1ps

module mono_framebuffer_draw_engine_top_test;
   import mfde_pkg::*;

   // Request type codes that the engine does not know; they must do nothing.
   localparam logic [2:0] REQ_BAD_LO = 3'd5;
   localparam logic [2:0] REQ_BAD_HI = 3'd7;

   localparam int RANDOM_REQUESTS = 1900;
   localparam int CALM_REQUESTS   = 150;
   localparam int PAUSE_AT        = 950;
   localparam int DRAIN_CYCLES    = 64;
   localparam int CYCLE_LIMIT     = 15_000_000;
   localparam int REPORT_LIMIT    = 10;

   typedef struct {
      logic [2:0] kind;
      logic [7:0] xa;
      logic [7:0] ya;
      logic [7:0] xb;
      logic [7:0] yb;
      logic [7:0] rad;
      logic       on;
      logic [6:0] col;
      logic [2:0] page;
   } draw_req_type;

   typedef struct {
      logic [7:0] data;
      logic       clip;
   } draw_rsp_type;

   typedef struct {
      draw_req_type rq;
      bit           typed;
      draw_rsp_type rsp;
   } table_row_type;

   logic clock;
   logic reset;

   mfde_req_if req_bus ();
   mfde_rsp_if rsp_bus ();

   mono_framebuffer_draw_engine_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Shadow copy of the framebuffer, one byte per column and page.
   logic [7:0] pixmap [STORE_BYTES];

   draw_rsp_type  pending_rsp [$];
   table_row_type directed_rows [$];
   int unsigned   fault_count;
   int unsigned   rsp_count;
   int unsigned   cycle_count;
   bit            calm;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run watchdog.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     pending_rsp.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Set or clear one pixel of the shadow store; returns 1 when it is off the display.
   function automatic bit put_pixel(input logic [7:0] x, input logic [7:0] y, input logic on);
      int page;
      int idx;
      page = int'(y) >> 3;
      if (int'(x) >= DISPLAY_COLUMNS || page >= DISPLAY_PAGES) return 1'b1;
      idx = int'(x) * DISPLAY_PAGES + page;
      if (on) pixmap[idx] = pixmap[idx] | (8'd1 << y[2:0]);
      else pixmap[idx] = pixmap[idx] & ~(8'd1 << y[2:0]);
      return 1'b0;
   endfunction

   // Error-accumulating line walk; each error steps its axis once it exceeds the long span.
   function automatic bit trace_line(input logic [7:0] xa, input logic [7:0] ya,
                                     input logic [7:0] xb, input logic [7:0] yb,
                                     input logic on);
      int dx;
      int dy;
      int span;
      int ex;
      int ey;
      logic [7:0] px;
      logic [7:0] py;
      logic [7:0] sx;
      logic [7:0] sy;
      bit clip;
      if (xb >= xa) begin
         dx = int'(xb) - int'(xa);
         sx = (dx != 0) ? 8'd1 : 8'd0;
      end else begin
         dx = int'(xa) - int'(xb);
         sx = 8'hFF;
      end
      if (yb >= ya) begin
         dy = int'(yb) - int'(ya);
         sy = (dy != 0) ? 8'd1 : 8'd0;
      end else begin
         dy = int'(ya) - int'(yb);
         sy = 8'hFF;
      end
      span = (dx > dy) ? dx : dy;
      px = xa;
      py = ya;
      ex = 0;
      ey = 0;
      clip = 1'b0;
      for (int n = 0; n <= span; n++) begin
         if (put_pixel(px, py, on)) clip = 1'b1;
         ex += dx;
         ey += dy;
         if (ex > span) begin
            ex -= span;
            px = px + sx;
         end
         if (ey > span) begin
            ey -= span;
            py = py + sy;
         end
      end
      return clip;
   endfunction

   // Octant walk of a circle, mirrored into eight points per step.
   function automatic bit trace_circle(input logic [7:0] cx, input logic [7:0] cy,
                                       input logic [7:0] r, input logic on);
      int a;
      int b;
      int rr;
      logic [7:0] ua;
      logic [7:0] ub;
      bit clip;
      a = 0;
      b = int'(r);
      rr = int'(r) * int'(r);
      clip = 1'b0;
      while (b >= 0 && 2 * b * b >= rr) begin
         ua = 8'(a);
         ub = 8'(b);
         if (put_pixel(cx + ua, cy - ub, on)) clip = 1'b1;
         if (put_pixel(cx - ua, cy - ub, on)) clip = 1'b1;
         if (put_pixel(cx - ua, cy + ub, on)) clip = 1'b1;
         if (put_pixel(cx + ua, cy + ub, on)) clip = 1'b1;
         if (put_pixel(cx + ub, cy + ua, on)) clip = 1'b1;
         if (put_pixel(cx + ub, cy - ua, on)) clip = 1'b1;
         if (put_pixel(cx - ub, cy - ua, on)) clip = 1'b1;
         if (put_pixel(cx - ub, cy + ua, on)) clip = 1'b1;
         a++;
         if (a * a + b * b - rr > 0) begin
            b--;
            a--;
         end
      end
      return clip;
   endfunction

   // Apply one request to the shadow store and work out its result.
   function automatic draw_rsp_type predict_draw(input draw_req_type rq);
      draw_rsp_type rsp;
      rsp.data = 8'd0;
      rsp.clip = 1'b0;
      case (rq.kind)
         REQ_CLEAR: begin
            foreach (pixmap[i]) pixmap[i] = 8'd0;
         end
         REQ_POINT: rsp.clip = put_pixel(rq.xa, rq.ya, rq.on);
         REQ_LINE: rsp.clip = trace_line(rq.xa, rq.ya, rq.xb, rq.yb, rq.on);
         REQ_CIRCLE: rsp.clip = trace_circle(rq.xa, rq.ya, rq.rad, rq.on);
         REQ_READ: begin
            if (int'(rq.col) < DISPLAY_COLUMNS && int'(rq.page) < DISPLAY_PAGES)
               rsp.data = pixmap[int'(rq.col) * DISPLAY_PAGES + int'(rq.page)];
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // Count a failure and describe the first few.
   function automatic void flag_fault(input string what);
      fault_count++;
      if (fault_count <= REPORT_LIMIT) $display("mismatch at result %0d: %s", rsp_count, what);
   endfunction

   // Build one row of the directed table.
   function automatic table_row_type make_row(input logic [2:0] kind, input int xa,
                                              input int ya, input int xb, input int yb,
                                              input int rad, input bit on, input int col,
                                              input int page, input bit typed,
                                              input int data, input bit clip);
      table_row_type row;
      row.rq.kind = kind;
      row.rq.xa = 8'(xa);
      row.rq.ya = 8'(ya);
      row.rq.xb = 8'(xb);
      row.rq.yb = 8'(yb);
      row.rq.rad = 8'(rad);
      row.rq.on = on;
      row.rq.col = 7'(col);
      row.rq.page = 3'(page);
      row.typed = typed;
      row.rsp.data = 8'(data);
      row.rsp.clip = clip;
      return row;
   endfunction

   // Coordinate mostly on the display, sometimes anywhere in the wrapped range.
   function automatic logic [7:0] pick_coord(input int span);
      if ($urandom_range(0, 4) != 0) return 8'($urandom_range(0, span - 1));
      return 8'($urandom_range(0, 255));
   endfunction

   // Random request; well-formed drawing on the display dominates, with rare clears.
   function automatic draw_req_type random_request();
      draw_req_type rq;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 1) rq.kind = REQ_CLEAR;
      else if (pick < 26) rq.kind = REQ_POINT;
      else if (pick < 56) rq.kind = REQ_LINE;
      else if (pick < 68) rq.kind = REQ_CIRCLE;
      else if (pick < 98) rq.kind = REQ_READ;
      else rq.kind = 3'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
      rq.xa = pick_coord(DISPLAY_COLUMNS);
      rq.ya = pick_coord(DISPLAY_PAGES * 8);
      rq.xb = pick_coord(DISPLAY_COLUMNS);
      rq.yb = pick_coord(DISPLAY_PAGES * 8);
      // Large circles are slow, so most radii stay small.
      pick = $urandom_range(0, 99);
      if (pick < 93) rq.rad = 8'($urandom_range(0, 40));
      else if (pick < 98) rq.rad = 8'($urandom_range(41, 127));
      else rq.rad = 8'($urandom_range(128, 255));
      rq.on = ($urandom_range(0, 3) != 0);
      rq.col = 7'($urandom_range(0, 127));
      rq.page = 3'($urandom_range(0, 7));
      return rq;
   endfunction

   // Present one request, wait for the handshake and queue what it should return.
   task automatic issue_request(input draw_req_type rq, input bit typed,
                                input draw_rsp_type typed_rsp);
      draw_rsp_type model_rsp;
      req_bus.valid <= 1'b1;
      req_bus.req_type <= rq.kind;
      req_bus.pos_x_a <= rq.xa;
      req_bus.pos_y_a <= rq.ya;
      req_bus.pos_x_b <= rq.xb;
      req_bus.pos_y_b <= rq.yb;
      req_bus.radius <= rq.rad;
      req_bus.set_mode <= rq.on;
      req_bus.read_column <= rq.col;
      req_bus.read_page <= rq.page;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      model_rsp = predict_draw(rq);
      pending_rsp.push_back(typed ? typed_rsp : model_rsp);
   endtask

   // Sender-side idle burst between requests.
   task automatic sender_gap();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // Hold the sender off until every queued result has come back.
   task automatic drain_pause();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_rsp.size() != 0);
   endtask

   // Receiver back-pressure in random bursts.
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 15) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // Compare every accepted result with the oldest expectation.
   always @(posedge clock) begin
      draw_rsp_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_rsp.size() == 0) begin
            flag_fault($sformatf("unexpected result data=%h clip=%b", rsp_bus.read_data,
                                 rsp_bus.clipped_any));
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_bus.read_data !== want.data)
               flag_fault($sformatf("read_data expected %h got %h", want.data,
                                    rsp_bus.read_data));
            if (rsp_bus.clipped_any !== want.clip)
               flag_fault($sformatf("clipped_any expected %b got %b", want.clip,
                                    rsp_bus.clipped_any));
         end
         rsp_count++;
      end
   end

   // Main sequence: reset, directed table, random requests, drain.
   initial begin
      draw_rsp_type none;
      none.data = 8'd0;
      none.clip = 1'b0;
      fault_count = 0;
      rsp_count = 0;
      calm = 1'b0;
      foreach (pixmap[i]) pixmap[i] = 8'd0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.req_type <= REQ_CLEAR;
      req_bus.pos_x_a <= 8'd0;
      req_bus.pos_y_a <= 8'd0;
      req_bus.pos_x_b <= 8'd0;
      req_bus.pos_y_b <= 8'd0;
      req_bus.radius <= 8'd0;
      req_bus.set_mode <= 1'b0;
      req_bus.read_column <= 7'd0;
      req_bus.read_page <= 3'd0;

      // Directed table: reads after reset, display corners, clipping, every drawing form.
      directed_rows.push_back(make_row(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00, 0));
      directed_rows.push_back(make_row(REQ_READ, 255, 255, 255, 255, 255, 1, 127, 7, 1, 8'h00, 0));
      directed_rows.push_back(make_row(REQ_POINT, 0, 0, 0, 0, 0, 1, 0, 0, 1, 8'h00, 0));
      directed_rows.push_back(make_row(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h01, 0));
      directed_rows.push_back(make_row(REQ_POINT, 127, 63, 0, 0, 0, 1, 0, 0, 1, 8'h00, 0));
      directed_rows.push_back(make_row(REQ_READ, 0, 0, 0, 0, 0, 0, 127, 7, 1, 8'h80, 0));
      directed_rows.push_back(make_row(REQ_POINT, 128, 0, 0, 0, 0, 1, 0, 0, 1, 8'h00, 1));
      directed_rows.push_back(make_row(REQ_POINT, 0, 64, 0, 0, 0, 1, 0, 0, 1, 8'h00, 1));
      directed_rows.push_back(make_row(REQ_POINT, 255, 255, 255, 255, 255, 1, 127, 7,
                                       1, 8'h00, 1));
      directed_rows.push_back(make_row(REQ_POINT, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00, 0));
      directed_rows.push_back(make_row(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h00, 0));
      directed_rows.push_back(make_row(REQ_LINE, 0, 0, 127, 63, 0, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(REQ_LINE, 127, 63, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(REQ_LINE, 10, 5, 10, 50, 0, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(REQ_LINE, 100, 20, 3, 20, 0, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(REQ_LINE, 255, 255, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(REQ_LINE, 40, 30, 40, 30, 0, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(REQ_CIRCLE, 64, 32, 0, 0, 0, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(REQ_CIRCLE, 64, 32, 0, 0, 255, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(REQ_CIRCLE, 64, 32, 0, 0, 20, 1, 0, 0, 0, 0, 0));
      directed_rows.push_back(make_row(REQ_READ, 0, 0, 0, 0, 0, 0, 64, 1, 0, 0, 0));
      directed_rows.push_back(make_row(REQ_BAD_LO, 255, 255, 255, 255, 255, 1, 64, 1,
                                       1, 8'h00, 0));
      directed_rows.push_back(make_row(REQ_BAD_HI, 200, 100, 0, 0, 9, 1, 64, 1, 1, 8'h00, 0));
      directed_rows.push_back(make_row(REQ_CLEAR, 0, 0, 0, 0, 0, 1, 0, 0, 1, 8'h00, 0));
      directed_rows.push_back(make_row(REQ_READ, 0, 0, 0, 0, 0, 0, 64, 1, 1, 8'h00, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].rsp);
         sender_gap();
      end
      drain_pause();

      // Random requests; the last stretch runs without idling on either side.
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS - CALM_REQUESTS) calm = 1'b1;
         issue_request(random_request(), 1'b0, none);
         if (n == PAUSE_AT) drain_pause();
         else sender_gap();
      end
      req_bus.valid <= 1'b0;

      // Wait for the last results, then a little longer for anything stray.
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fault_count == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
